### rtl/core/tscan_pkg.sv
// Package for the token scanner: token kinds, scan modes, the result record
// and the keyword table with small character helpers.
// Depends on nothing; used by token_scanner.
package tscan_pkg;

  localparam int OFFSET_BITS_DEF = 16;
  localparam int LINE_BITS_DEF   = 16;
  localparam int WIDE            = 34;  // holds any offset plus one, unclamped
  localparam int MAX_TOKENS      = 4;

  localparam logic [5:0] K_DOT      = 6'd7;
  localparam logic [5:0] K_BANG     = 6'd13;
  localparam logic [5:0] K_EQUAL    = 6'd15;
  localparam logic [5:0] K_LESS     = 6'd17;
  localparam logic [5:0] K_GREATER  = 6'd19;
  localparam logic [5:0] K_SLASH    = 6'd21;
  localparam logic [5:0] K_STRING   = 6'd22;
  localparam logic [5:0] K_NUMBER   = 6'd23;
  localparam logic [5:0] K_IDENT    = 6'd24;
  localparam logic [5:0] K_KW0      = 6'd25;
  localparam logic [5:0] K_EOF      = 6'd41;
  localparam logic [5:0] K_BADCHAR  = 6'd42;
  localparam logic [5:0] K_UNTERM   = 6'd43;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef enum logic [11:0] {
    M_IDLE    = 12'b0000_0000_0001,
    M_BANG    = 12'b0000_0000_0010,
    M_EQ      = 12'b0000_0000_0100,
    M_LT      = 12'b0000_0000_1000,
    M_GT      = 12'b0000_0001_0000,
    M_SLASH   = 12'b0000_0010_0000,
    M_COMMENT = 12'b0000_0100_0000,
    M_STRING  = 12'b0000_1000_0000,
    M_INT     = 12'b0001_0000_0000,
    M_DOT     = 12'b0010_0000_0000,
    M_FRAC    = 12'b0100_0000_0000,
    M_WORD    = 12'b1000_0000_0000
  } mode_t;

  typedef logic [5:0][7:0] word_t;  // byte 0 is the first character

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
    logic [15:0] line;
    logic        last;
  } tok_t;

  function automatic logic [15:0] clamp16(input logic [WIDE-1:0] v);
    clamp16 = (v > WIDE'(65535)) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [WIDE-1:0] sub0(input logic [WIDE-1:0] a, input logic [WIDE-1:0] b);
    sub0 = (a > b) ? a - b : '0;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  // Keyword text, written back to front so that the first character lands
  // in the lowest byte; unused bytes are zero.
  function automatic word_t kw_word(input logic [3:0] i);
    unique case (i)
      4'd0:  kw_word = 48'("dna");
      4'd1:  kw_word = 48'("ssalc");
      4'd2:  kw_word = 48'("esle");
      4'd3:  kw_word = 48'("eslaf");
      4'd4:  kw_word = 48'("rof");
      4'd5:  kw_word = 48'("nuf");
      4'd6:  kw_word = 48'("fi");
      4'd7:  kw_word = 48'("lin");
      4'd8:  kw_word = 48'("ro");
      4'd9:  kw_word = 48'("tnirp");
      4'd10: kw_word = 48'("nruter");
      4'd11: kw_word = 48'("repus");
      4'd12: kw_word = 48'("siht");
      4'd13: kw_word = 48'("eurt");
      4'd14: kw_word = 48'("rav");
      default: kw_word = 48'("elihw");
    endcase
  endfunction

  // Single-character punctuation; the kind equals the table position.
  function automatic logic [6:0] single_kind(input logic [7:0] c);
    unique case (c)
      "(": single_kind = {1'b1, 6'd0};
      ")": single_kind = {1'b1, 6'd1};
      "{": single_kind = {1'b1, 6'd2};
      "}": single_kind = {1'b1, 6'd3};
      "[": single_kind = {1'b1, 6'd4};
      "]": single_kind = {1'b1, 6'd5};
      ",": single_kind = {1'b1, 6'd6};
      ".": single_kind = {1'b1, 6'd7};
      "-": single_kind = {1'b1, 6'd8};
      "+": single_kind = {1'b1, 6'd9};
      ";": single_kind = {1'b1, 6'd10};
      "*": single_kind = {1'b1, 6'd11};
      "%": single_kind = {1'b1, 6'd12};
      default: single_kind = '0;
    endcase
  endfunction

endpackage

### rtl/core/token_scanner.sv
// Top level of the streaming Lox token scanner: scan state and token buffer.
// Depends on tscan_pkg.
//
// The scanner takes one source byte per request (in_tuser low) and an
// end-of-source request (in_tuser high), and answers each with zero to three
// token results: operators, strings, numbers, identifiers, keywords, error
// kinds and a final EOF. A request is scanned in the cycle it is accepted,
// by one pass of mode logic on the registered scan state, and its tokens are
// loaded into a four-slot output buffer; a new request is taken whenever the
// buffer will be empty after the current cycle. While out_tready is high, the
// buffer drains one token per cycle and text with at most one token per byte
// flows at one byte per clock; a byte with more tokens holds the input until
// all but its last have drained. There is no clearing pass after reset.
// Offsets and line numbers saturate; the reported fields stop at 16 bits.
module token_scanner
  import tscan_pkg::*;
#(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] byte_req
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] start_offset, [31:16] length, [47:32] line
  output logic [5:0]  out_tuser,  // [5:0] kind
  output logic        out_tlast   // last_of_run
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX  = {OFFSET_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};

  // Scan state.
  mode_t                  mode_r, mode_nxt;
  logic [OFFSET_BITS-1:0] ts_r, ts_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  word_t                  wc_r, wc_nxt;
  logic [2:0]             wcnt_r, wcnt_nxt;
  logic                   wlong_r, wlong_nxt;

  // Output buffer: slot 0 is the token on the port.
  tok_t       buf_r [MAX_TOKENS];
  logic [2:0] cnt_r;

  tok_t       tk [MAX_TOKENS];
  logic [2:0] n;
  logic       in_acc, out_acc, rescan;
  logic [WIDE-1:0] p_w, ts_w, dot_w;
  logic [15:0]     line16;
  logic [5:0]      word_kind, base;
  logic [6:0]      sk;
  logic [7:0]      c;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign in_tready = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_tready);

  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tuser  = buf_r[0].kind;
  assign out_tdata  = {buf_r[0].line, buf_r[0].len, buf_r[0].start};
  assign out_tlast  = buf_r[0].last;

  assign c      = in_tdata;
  assign p_w    = WIDE'(pos_r);
  assign ts_w   = WIDE'(ts_r);
  assign dot_w  = (pos_r != '0) ? p_w - WIDE'(1) : '0;
  assign line16 = clamp16(WIDE'(line_r));

  // Keyword lookup on the stored word; words longer than six are identifiers.
  always_comb begin
    word_kind = K_IDENT;
    if (!wlong_r) begin
      for (int i = MAX_TOKENS * 4 - 1; i >= 0; i--) begin
        if (wc_r == kw_word(4'(i))) word_kind = K_KW0 + 6'(i);
      end
    end
  end

  always_comb begin
    unique case (mode_r)
      M_BANG:  base = K_BANG;
      M_EQ:    base = K_EQUAL;
      M_LT:    base = K_LESS;
      default: base = K_GREATER;
    endcase
  end

  assign sk = single_kind(c);

  // One pass of the scanner over the request: finish the pending token if
  // this byte ends it, then scan the byte from idle when it was not consumed.
  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) tk[i] = '0;
    n         = '0;
    rescan    = 1'b0;
    mode_nxt  = mode_r;
    ts_nxt    = ts_r;
    pos_nxt   = (pos_r < OFF_MAX) ? pos_r + 1'b1 : pos_r;
    line_nxt  = line_r;
    wc_nxt    = wc_r;
    wcnt_nxt  = wcnt_r;
    wlong_nxt = wlong_r;
    if (in_tuser == CMD_END) begin
      unique case (mode_r)
        M_BANG, M_EQ, M_LT, M_GT: begin
          tk[0] = '{base, clamp16(ts_w), 16'd1, line16, 1'b0};
          n = 3'd1;
        end
        M_SLASH: begin
          tk[0] = '{K_SLASH, clamp16(ts_w), 16'd1, line16, 1'b0};
          n = 3'd1;
        end
        M_STRING: begin
          tk[0] = '{K_UNTERM, clamp16(ts_w), clamp16(sub0(p_w, ts_w)), line16, 1'b0};
          n = 3'd1;
        end
        M_INT, M_FRAC: begin
          tk[0] = '{K_NUMBER, clamp16(ts_w), clamp16(sub0(p_w, ts_w)), line16, 1'b0};
          n = 3'd1;
        end
        M_DOT: begin
          tk[0] = '{K_NUMBER, clamp16(ts_w), clamp16(sub0(dot_w, ts_w)), line16, 1'b0};
          tk[1] = '{K_DOT, clamp16(dot_w), 16'd1, line16, 1'b0};
          n = 3'd2;
        end
        M_WORD: begin
          tk[0] = '{word_kind, clamp16(ts_w), clamp16(sub0(p_w, ts_w)), line16, 1'b0};
          n = 3'd1;
        end
        default: n = 3'd0;
      endcase
      tk[n[1:0]] = '{K_EOF, clamp16(p_w), 16'd0, line16, 1'b0};
      n = n + 3'd1;
      // End of source restarts the scanner.
      mode_nxt  = M_IDLE;
      ts_nxt    = '0;
      pos_nxt   = '0;
      line_nxt  = LINE_BITS'(1);
      wc_nxt    = '0;
      wcnt_nxt  = '0;
      wlong_nxt = 1'b0;
    end else begin
      unique case (mode_r)
        M_BANG, M_EQ, M_LT, M_GT: begin
          mode_nxt = M_IDLE;
          if (c == "=") begin
            tk[0] = '{base + 6'd1, clamp16(ts_w), 16'd2, line16, 1'b0};
          end else begin
            tk[0] = '{base, clamp16(ts_w), 16'd1, line16, 1'b0};
            rescan = 1'b1;
          end
          n = 3'd1;
        end
        M_SLASH: begin
          if (c == "/") begin
            mode_nxt = M_COMMENT;
          end else begin
            mode_nxt = M_IDLE;
            tk[0] = '{K_SLASH, clamp16(ts_w), 16'd1, line16, 1'b0};
            n = 3'd1;
            rescan = 1'b1;
          end
        end
        M_COMMENT: begin
          // The newline that ends a comment is then counted from idle.
          if (c == "\n") begin
            mode_nxt = M_IDLE;
            rescan = 1'b1;
          end
        end
        M_STRING: begin
          if (c == "\"") begin
            tk[0] = '{K_STRING, clamp16(ts_w), clamp16(sub0(p_w, ts_w) + WIDE'(1)),
                      line16, 1'b0};
            n = 3'd1;
            mode_nxt = M_IDLE;
          end else if (c == "\n") begin
            line_nxt = (line_r < LINE_MAX) ? line_r + 1'b1 : line_r;
          end
        end
        M_INT, M_FRAC: begin
          if (is_digit(c)) begin
            mode_nxt = mode_r;
          end else if ((mode_r == M_INT) && (c == ".")) begin
            mode_nxt = M_DOT;
          end else begin
            tk[0] = '{K_NUMBER, clamp16(ts_w), clamp16(sub0(p_w, ts_w)), line16, 1'b0};
            n = 3'd1;
            mode_nxt = M_IDLE;
            rescan = 1'b1;
          end
        end
        M_DOT: begin
          // A dot without a following digit is a token of its own.
          if (is_digit(c)) begin
            mode_nxt = M_FRAC;
          end else begin
            tk[0] = '{K_NUMBER, clamp16(ts_w), clamp16(sub0(dot_w, ts_w)), line16, 1'b0};
            tk[1] = '{K_DOT, clamp16(dot_w), 16'd1, line16, 1'b0};
            n = 3'd2;
            mode_nxt = M_IDLE;
            rescan = 1'b1;
          end
        end
        M_WORD: begin
          if (is_alpha(c) || is_digit(c)) begin
            if (wcnt_r < 3'd6) begin
              wc_nxt[wcnt_r] = c;
              wcnt_nxt = wcnt_r + 3'd1;
            end else begin
              wlong_nxt = 1'b1;
            end
          end else begin
            tk[0] = '{word_kind, clamp16(ts_w), clamp16(sub0(p_w, ts_w)), line16, 1'b0};
            n = 3'd1;
            mode_nxt = M_IDLE;
            rescan = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase

      if (rescan) begin
        ts_nxt = pos_r;
        if (sk[6]) begin
          tk[n[1:0]] = '{sk[5:0], clamp16(p_w), 16'd1, line16, 1'b0};
          n = n + 3'd1;
        end else if (c == "!") begin
          mode_nxt = M_BANG;
        end else if (c == "=") begin
          mode_nxt = M_EQ;
        end else if (c == "<") begin
          mode_nxt = M_LT;
        end else if (c == ">") begin
          mode_nxt = M_GT;
        end else if (c == "/") begin
          mode_nxt = M_SLASH;
        end else if ((c == " ") || (c == "\r") || (c == "\t")) begin
          mode_nxt = M_IDLE;
        end else if (c == "\n") begin
          line_nxt = (line_r < LINE_MAX) ? line_r + 1'b1 : line_r;
        end else if (c == "\"") begin
          mode_nxt = M_STRING;
        end else if (is_digit(c)) begin
          mode_nxt = M_INT;
        end else if (is_alpha(c)) begin
          wc_nxt    = '0;
          wc_nxt[0] = c;
          wcnt_nxt  = 3'd1;
          wlong_nxt = 1'b0;
          mode_nxt  = M_WORD;
        end else begin
          tk[n[1:0]] = '{K_BADCHAR, clamp16(p_w), 16'd1, line16, 1'b0};
          n = n + 3'd1;
        end
      end
    end
    if (n != 3'd0) tk[2'(n - 3'd1)].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      ts_r    <= '0;
      pos_r   <= '0;
      line_r  <= LINE_BITS'(1);
      wc_r    <= '0;
      wcnt_r  <= '0;
      wlong_r <= 1'b0;
    end else if (in_acc) begin
      mode_r  <= mode_nxt;
      ts_r    <= ts_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      wc_r    <= wc_nxt;
      wcnt_r  <= wcnt_nxt;
      wlong_r <= wlong_nxt;
    end
  end

  // The buffer is empty or draining its last token whenever a request is
  // taken, so a load simply replaces all slots.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= n;
    end else if (out_acc) begin
      cnt_r <= cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_TOKENS; i++) buf_r[i] <= tk[i];
    end else if (out_acc) begin
      for (int i = 0; i < MAX_TOKENS - 1; i++) buf_r[i] <= buf_r[i + 1];
    end
  end

  // The buffer never holds more than one request's worth of tokens.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'(MAX_TOKENS))
    else $error("token buffer overfilled");

  // End of source always yields at least the EOF token.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == CMD_END)) |=> out_tvalid)
    else $error("end of source gave no token");

  // End of source restarts the offset count.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_tuser == CMD_END)) |=> (pos_r == '0) && (mode_r == M_IDLE))
    else $error("scanner not restarted after end of source");

  // A new request is only taken once the previous tokens are nearly gone.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ((cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_acc)))
    else $error("request accepted over pending tokens");

endmodule

### tb/token_scanner_checker.sv
// Checker for the token scanner: watches both stream channels, predicts the
// tokens of every accepted request and compares them with the results.
// Depends on tscan_pkg for the token kinds and request codes.
`timescale 1ns / 100ps
module token_scanner_checker
  import tscan_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic [5:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          tokens_pending
);

  // Scan modes of the predictor.
  typedef enum int {
    SM_IDLE, SM_BANG, SM_EQ, SM_LT, SM_GT, SM_SLASH, SM_COMMENT,
    SM_STRING, SM_INT, SM_DOT, SM_FRAC, SM_WORD
  } scan_mode_e;

  localparam int OFF_MAX  = 65535;
  localparam int LINE_MAX = 65535;

  tok_t       token_queue[$];
  scan_mode_e mode;
  int         tok_begin;
  int         pos;
  int         line_no;
  logic [7:0] word_text[6];
  int         word_len;
  bit         word_long;
  int         n_emitted;

  assign tokens_pending = token_queue.size();

  function automatic bit digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic int nonneg_diff(input int a, input int b);
    return a > b ? a - b : 0;
  endfunction

  // Appends one predicted token; the last flag is fixed up per request.
  // Reported fields stop at 16 bits.
  function automatic void push_token(input logic [5:0] kind, input int s, input int n);
    tok_t t;
    t.kind  = kind;
    t.start = (s > 65535) ? 16'hFFFF : 16'(s);
    t.len   = (n > 65535) ? 16'hFFFF : 16'(n);
    t.line  = (line_no > 65535) ? 16'hFFFF : 16'(line_no);
    t.last  = 1'b0;
    token_queue = {token_queue, t};
    n_emitted++;
  endfunction

  function automatic void reset_scan();
    mode      = SM_IDLE;
    tok_begin = 0;
    pos       = 0;
    line_no   = 1;
    word_len  = 0;
    word_long = 0;
    foreach (word_text[i]) word_text[i] = 8'h00;
  endfunction

  function automatic void bump_line();
    if (line_no < LINE_MAX) line_no++;
  endfunction

  // Keywords are only recognized for words of six characters or fewer.
  function automatic void push_word(input int stop);
    string kws[16] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                       "or", "print", "return", "super", "this", "true", "var", "while"};
    logic [5:0] kind;
    string w;
    kind = K_IDENT;
    w = "";
    for (int i = 0; i < word_len; i++) w = {w, string'(word_text[i])};
    if (!word_long)
      for (int i = 0; i < 16; i++)
        if (kws[i] == w) begin
          kind = K_KW0 + 6'(i);
          break;
        end
    push_token(kind, tok_begin, nonneg_diff(stop, tok_begin));
  endfunction

  // A number followed by a lone dot gives the number and then the dot.
  function automatic void push_number_dot(input int p);
    int d;
    d = p > 0 ? p - 1 : 0;
    push_token(K_NUMBER, tok_begin, nonneg_diff(d, tok_begin));
    push_token(K_DOT, d, 1);
  endfunction

  function automatic logic [5:0] op_kind(input scan_mode_e m);
    case (m)
      SM_BANG: return K_BANG;
      SM_EQ:   return K_EQUAL;
      SM_LT:   return K_LESS;
      default: return K_GREATER;
    endcase
  endfunction

  function automatic void scan_from_idle(input logic [7:0] c, input int p);
    string singles = "(){}[],.-+;*%";
    tok_begin = p;
    for (int i = 0; i < 13; i++)
      if (singles[i] == c) begin
        push_token(6'(i), p, 1);
        return;
      end
    case (c)
      "!": mode = SM_BANG;
      "=": mode = SM_EQ;
      "<": mode = SM_LT;
      ">": mode = SM_GT;
      "/": mode = SM_SLASH;
      " ", 8'h0d, 8'h09: ;
      8'h0a: bump_line();
      "\"": mode = SM_STRING;
      default: begin
        if (digit(c)) mode = SM_INT;
        else if (letter(c)) begin
          foreach (word_text[i]) word_text[i] = 8'h00;
          word_text[0] = c;
          word_len = 1;
          word_long = 0;
          mode = SM_WORD;
        end else push_token(K_BADCHAR, p, 1);
      end
    endcase
  endfunction

  // Continues a pending token; returns 1 when the byte must be rescanned.
  function automatic bit scan_in_mode(input logic [7:0] c, input int p);
    scan_mode_e m;
    m = mode;
    case (m)
      SM_BANG, SM_EQ, SM_LT, SM_GT: begin
        mode = SM_IDLE;
        if (c == "=") begin
          push_token(op_kind(m) + 6'd1, tok_begin, 2);
          return 0;
        end
        push_token(op_kind(m), tok_begin, 1);
        return 1;
      end
      SM_SLASH: begin
        if (c == "/") begin
          mode = SM_COMMENT;
          return 0;
        end
        mode = SM_IDLE;
        push_token(K_SLASH, tok_begin, 1);
        return 1;
      end
      SM_COMMENT: begin
        if (c == 8'h0a) begin
          mode = SM_IDLE;
          return 1;
        end
        return 0;
      end
      SM_STRING: begin
        if (c == "\"") begin
          push_token(K_STRING, tok_begin, nonneg_diff(p, tok_begin) + 1);
          mode = SM_IDLE;
        end else if (c == 8'h0a) bump_line();
        return 0;
      end
      SM_INT: begin
        if (digit(c)) return 0;
        if (c == ".") begin
          mode = SM_DOT;
          return 0;
        end
        push_token(K_NUMBER, tok_begin, nonneg_diff(p, tok_begin));
        mode = SM_IDLE;
        return 1;
      end
      SM_DOT: begin
        if (digit(c)) begin
          mode = SM_FRAC;
          return 0;
        end
        push_number_dot(p);
        mode = SM_IDLE;
        return 1;
      end
      SM_FRAC: begin
        if (digit(c)) return 0;
        push_token(K_NUMBER, tok_begin, nonneg_diff(p, tok_begin));
        mode = SM_IDLE;
        return 1;
      end
      SM_WORD: begin
        if (letter(c) || digit(c)) begin
          if (word_len < 6) word_text[word_len++] = c;
          else word_long = 1;
          return 0;
        end
        push_word(p);
        mode = SM_IDLE;
        return 1;
      end
      default: begin
        mode = SM_IDLE;
        return 1;
      end
    endcase
  endfunction

  function automatic void flush_pending(input int p);
    case (mode)
      SM_BANG, SM_EQ, SM_LT, SM_GT: push_token(op_kind(mode), tok_begin, 1);
      SM_SLASH:       push_token(K_SLASH, tok_begin, 1);
      SM_STRING:      push_token(K_UNTERM, tok_begin, nonneg_diff(p, tok_begin));
      SM_INT, SM_FRAC: push_token(K_NUMBER, tok_begin, nonneg_diff(p, tok_begin));
      SM_DOT:         push_number_dot(p);
      SM_WORD:        push_word(p);
      default: ;
    endcase
  endfunction

  function automatic void predict_request(input logic cmd, input logic [7:0] c);
    int p;
    p = pos;
    n_emitted = 0;
    if (cmd == CMD_END) begin
      flush_pending(p);
      push_token(K_EOF, p, 0);
      reset_scan();
    end else begin
      if (mode == SM_IDLE || scan_in_mode(c, p)) scan_from_idle(c, p);
      if (pos < OFF_MAX) pos++;
    end
    if (n_emitted > 0) token_queue[token_queue.size() - 1].last = 1'b1;
  endfunction

  initial reset_scan();

  always @(posedge clk) begin
    tok_t got, want;
    if (!rst_n) begin
      reset_scan();
      token_queue.delete();
      fail_count <= 0;
    end else begin
      // Results are compared before the request of the same edge is scanned,
      // since a token is registered when its request goes in and leaves later.
      if (out_tvalid && out_tready) begin
        got = {out_tuser, out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tlast};
        if (token_queue.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected token kind=%0d start=%0d len=%0d line=%0d",
                     $realtime, got.kind, got.start, got.len, got.line);
          fail_count <= fail_count + 1;
        end else begin
          want = token_queue.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("%0t: token mismatch exp k=%0d s=%0d n=%0d l=%0d t=%0b got k=%0d s=%0d n=%0d l=%0d t=%0b",
                       $realtime, want.kind, want.start, want.len, want.line, want.last,
                       got.kind, got.start, got.len, got.line, got.last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready) predict_request(in_tuser, in_tdata);
    end
  end

endmodule

### tb/tb_token_scanner.sv
// Testbench top for the token scanner: clock, reset, request stimulus and
// verdict. Depends on tscan_pkg, token_scanner and token_scanner_checker.
`timescale 1ns / 100ps
module tb_token_scanner;
  import tscan_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = CMD_BYTE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [5:0]  out_tuser;
  logic        out_tlast;
  int          fail_count;
  int          tokens_pending;
  bit          sink_quiet;   // stretches with the result side always ready
  bit          source_quiet; // stretches with no gaps between requests
  int          sink_gap;     // cycles left in the current result-side stall
  int          n_sent = 0;   // requests accepted so far

  always #1 clk = ~clk;

  token_scanner DUT (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );

  token_scanner_checker u_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .fail_count, .tokens_pending
  );

  // Gap lengths: mostly none or short, now and then long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // The result side stalls for random stretches, except in quiet stretches.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_gap   <= 0;
    end else if (sink_quiet) begin
      out_tready <= 1'b1;
    end else if (sink_gap > 0) begin
      out_tready <= 1'b0;
      sink_gap   <= sink_gap - 1;
    end else if ($urandom_range(0, 99) < 40) begin
      out_tready <= 1'b0;
      sink_gap   <= gap_len();
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      sink_quiet = ~sink_quiet;
      source_quiet = $urandom_range(0, 2) == 0;
    end
  end

  // Drives one request and holds it until it is accepted.
  task automatic send_request(input logic cmd, input logic [7:0] b);
    int g;
    g = source_quiet ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(CMD_BYTE, s[i]);
  endtask

  // Source-like text with random content, plus the odd random byte.
  task automatic send_random_piece();
    string pieces[24] = '{"and", "class", "else", "false", "for", "fun", "if", "nil",
                          "or", "print", "return", "super", "this", "true", "var",
                          "while", "x_1", "abcdefgh", "12", "3.75", "9.", "!=", "<=",
                          "// note\n"};
    string ops = "(){}[],.-+;*%!=<>/ \t\r\n\"";
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) send_text(pieces[$urandom_range(0, 23)]);
    else if (r < 75) send_request(CMD_BYTE, ops[$urandom_range(0, ops.len() - 1)]);
    else if (r < 85) send_request(CMD_BYTE, 8'($urandom_range(0, 255)));
    else if (r < 92) send_text("\"ab\ncd\"");
    else send_request(CMD_BYTE, " ");
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: operators, identifiers, numbers with and without a
    // fraction, a comment, a multi-line string and odd bytes.
    send_text("(!= ==<>=/x//c\n");
    send_text("while_ 12.5 7.a \"s\n\"");
    send_request(CMD_BYTE, 8'h00);
    send_request(CMD_BYTE, 8'hFF);
    send_text("3.");
    send_request(CMD_END, 8'h00);   // number then dot flushed before EOF
    send_text("\"open");
    send_request(CMD_END, 8'hFF);   // unterminated string at end

    // Random part, until about 480 requests have gone in.
    while (n_sent < 480) begin
      send_random_piece();
      if ($urandom_range(0, 39) == 0) send_request(CMD_END, 8'($urandom_range(0, 255)));
    end
    send_request(CMD_END, 8'h00);
    in_tvalid <= 1'b0;

    while (tokens_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && tokens_pending == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
